// File: rtl/core/stdq_pkg.sv
// Shared types and constants for the sorted timer deadline queue.
// Holds the operation and status codes and the controller command bundle.
// No dependencies.
package stdq_pkg;

    localparam int MAX_TIMERS_DEF = 16;
    localparam int TICK_BITS_DEF  = 32;

    localparam int OP_W      = 3;
    localparam int ID_W      = 4;
    localparam int STATUS_W  = 3;
    localparam int PORT_TICK_W = 32;
    localparam int ID_SPACE  = 1 << ID_W;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_PEEK     = 3'd2,
        OP_NEXT     = 3'd3,
        OP_CONTAINS = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_ALREADY     = 3'd1,
        ST_NOT_QUEUED  = 3'd2,
        ST_FULL        = 3'd3,
        ST_EMPTY       = 3'd4,
        ST_NOT_EXPIRED = 3'd5
    } status_t;

    typedef struct packed {
        logic load;
        logic exec;
    } stdq_cmd_t;

endpackage

// File: rtl/core/stdq_ctrl.sv
// Request sequencer for the sorted timer deadline queue.
// Steps each request through capture and execution and owns the result valid.
// Depends on stdq_pkg.
module stdq_ctrl
    import stdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output stdq_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign cmd.load  = in_valid && (state_reg == S_IDLE);
    assign cmd.exec  = (state_reg == S_EXEC) && slot_free;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/stdq_datapath.sv
// Datapath of the sorted timer deadline queue: request registers, the
// shifting sorted cell array, membership flags and the result register.
// Depends on stdq_pkg.
module stdq_datapath
    import stdq_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF,
    parameter int TICK_BITS  = TICK_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  stdq_cmd_t              cmd,
    input  logic [OP_W-1:0]        operation,
    input  logic [ID_W-1:0]        timer_id,
    input  logic [PORT_TICK_W-1:0] deadline_tick,
    input  logic [PORT_TICK_W-1:0] current_tick,
    output logic [STATUS_W-1:0]    status,
    output logic                   found,
    output logic [ID_W-1:0]        result_id,
    output logic [PORT_TICK_W-1:0] result_tick
);

    localparam int CNT_W = $clog2(MAX_TIMERS + 1);
    localparam int EXT_W = (TICK_BITS > PORT_TICK_W) ? TICK_BITS : PORT_TICK_W;

    function automatic logic tick_before(input logic [TICK_BITS-1:0] a,
                                         input logic [TICK_BITS-1:0] b);
        logic [TICK_BITS-1:0] d;
        d = a - b;
        return d[TICK_BITS-1];
    endfunction

    logic [OP_W-1:0]        req_op_reg;
    logic [ID_W-1:0]        req_id_reg;
    logic [TICK_BITS-1:0]   req_exp_reg;
    logic [TICK_BITS-1:0]   req_now_reg;
    logic [EXT_W-1:0]       exp_ext;
    logic [EXT_W-1:0]       now_ext;

    logic [ID_W-1:0]        ids_reg   [MAX_TIMERS];
    logic [TICK_BITS-1:0]   ticks_reg [MAX_TIMERS];
    logic [ID_W-1:0]        ids_next  [MAX_TIMERS];
    logic [TICK_BITS-1:0]   ticks_next[MAX_TIMERS];
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [ID_SPACE-1:0]    flags_reg, flags_next;

    logic [STATUS_W-1:0]    status_reg, status_next;
    logic                   found_reg, found_next;
    logic [ID_W-1:0]        rid_reg, rid_next;
    logic [PORT_TICK_W-1:0] rtick_reg, rtick_next;

    logic [MAX_TIMERS-1:0]  gt_vec;
    logic [MAX_TIMERS-1:0]  past_vec;
    logic [EXT_W-1:0]       head_ext;
    logic                   id_ok;
    logic                   flag_q;
    logic                   empty;
    logic                   full;
    logic                   do_ins;
    logic                   do_rem;

    assign exp_ext  = EXT_W'(deadline_tick);
    assign now_ext  = EXT_W'(current_tick);
    assign head_ext = EXT_W'(ticks_reg[0]);
    assign id_ok    = (32'(req_id_reg) < 32'(MAX_TIMERS));
    assign flag_q   = id_ok && flags_reg[req_id_reg];
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(MAX_TIMERS));

    // A cell moves up once it or any cell below it is unused or strictly later
    // than the new tick. Wrap-around order keeps the raw compare from being
    // monotone, so the first such cell is carried upward.
    always_comb
    begin
        gt_vec[0] = (count_reg == '0) || tick_before(req_exp_reg, ticks_reg[0]);
        for (int k = 1; k < MAX_TIMERS; k++)
        begin
            gt_vec[k] = gt_vec[k-1] || (CNT_W'(k) >= count_reg)
                        || tick_before(req_exp_reg, ticks_reg[k]);
        end
        past_vec[0] = (count_reg != '0) && (ids_reg[0] == req_id_reg);
        for (int k = 1; k < MAX_TIMERS; k++)
        begin
            past_vec[k] = past_vec[k-1]
                          || ((CNT_W'(k) < count_reg) && (ids_reg[k] == req_id_reg));
        end
    end

    always_comb
    begin
        status_next = ST_OK;
        found_next  = 1'b0;
        rid_next    = '0;
        rtick_next  = '0;
        do_ins      = 1'b0;
        do_rem      = 1'b0;
        case (req_op_reg)
            OP_INSERT:
            begin
                if (!id_ok)
                begin
                    status_next = ST_NOT_QUEUED;
                end
                else if (flag_q)
                begin
                    status_next = ST_ALREADY;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (!flag_q)
                begin
                    status_next = ST_NOT_QUEUED;
                end
                else
                begin
                    do_rem = 1'b1;
                end
            end
            OP_PEEK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (tick_before(req_now_reg, ticks_reg[0]))
                begin
                    status_next = ST_NOT_EXPIRED;
                end
                else
                begin
                    found_next = 1'b1;
                    rid_next   = ids_reg[0];
                end
            end
            OP_NEXT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    found_next = 1'b1;
                    rtick_next = head_ext[PORT_TICK_W-1:0];
                end
            end
            OP_CONTAINS:
            begin
                found_next = flag_q;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        flags_next = flags_reg;
        for (int k = 0; k < MAX_TIMERS; k++)
        begin
            ids_next[k]   = ids_reg[k];
            ticks_next[k] = ticks_reg[k];
        end
        if (cmd.exec && do_ins)
        begin
            count_next             = count_reg + 1'b1;
            flags_next[req_id_reg] = 1'b1;
            for (int k = 0; k < MAX_TIMERS; k++)
            begin
                if (gt_vec[k])
                begin
                    if ((k == 0) || !gt_vec[(k == 0) ? 0 : k-1])
                    begin
                        ids_next[k]   = req_id_reg;
                        ticks_next[k] = req_exp_reg;
                    end
                    else
                    begin
                        ids_next[k]   = ids_reg[(k == 0) ? 0 : k-1];
                        ticks_next[k] = ticks_reg[(k == 0) ? 0 : k-1];
                    end
                end
            end
        end
        else if (cmd.exec && do_rem)
        begin
            count_next             = count_reg - 1'b1;
            flags_next[req_id_reg] = 1'b0;
            for (int k = 0; k < MAX_TIMERS - 1; k++)
            begin
                if (past_vec[k])
                begin
                    ids_next[k]   = ids_reg[k+1];
                    ticks_next[k] = ticks_reg[k+1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            flags_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_TIMERS; k++)
        begin
            ids_reg[k]   <= ids_next[k];
            ticks_reg[k] <= ticks_next[k];
        end
        if (cmd.load)
        begin
            req_op_reg  <= operation;
            req_id_reg  <= timer_id;
            req_exp_reg <= exp_ext[TICK_BITS-1:0];
            req_now_reg <= now_ext[TICK_BITS-1:0];
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
            rid_reg    <= rid_next;
            rtick_reg  <= rtick_next;
        end
    end

    assign status      = status_reg;
    assign found       = found_reg;
    assign result_id   = rid_reg;
    assign result_tick = rtick_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TIMERS))
        else $error("queue count exceeds capacity");

    a_flags_match_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(flags_reg) == 32'(count_reg))
        else $error("membership flags disagree with queue count");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && do_ins) |=> (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("accepted insert did not grow the queue");

    a_remove_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && do_rem) |=> !flags_reg[$past(req_id_reg)])
        else $error("removed timer still marked queued");
`endif

endmodule

// File: rtl/core/sorted_timer_deadline_queue.sv
// Sorted timer deadline queue, top level.
// Joins the request sequencer (stdq_ctrl) and the sorted cell datapath
// (stdq_datapath); depends on stdq_pkg.
//
// Usage: a request enters on in_valid/in_ready with operation, timer_id,
// deadline_tick and current_tick, and yields exactly one result on
// out_valid/out_ready with status, found, result_id and result_tick.
// Timers sit in a row of cells kept sorted by wrap-around tick order; an
// insert shifts later cells up by one and a remove shifts later cells down,
// all cells moving in the same cycle.
// The request is captured at the accepting edge and executed in the S_EXEC
// state once the output register is free; that step also raises out_valid.
// A new request is not accepted until the last one has left its capture and
// execute steps. A finished result waits in the output register while the next
// request is accepted; if the receiver stalls, execution of that next
// request waits until the output register frees, and input stalls behind it.
// Reset empties the queue and clears all membership flags; no clearing pass
// is needed.
module sorted_timer_deadline_queue
    import stdq_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF,
    parameter int TICK_BITS  = TICK_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [OP_W-1:0]        operation,
    input  logic [ID_W-1:0]        timer_id,
    input  logic [PORT_TICK_W-1:0] deadline_tick,
    input  logic [PORT_TICK_W-1:0] current_tick,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [STATUS_W-1:0]    status,
    output logic                   found,
    output logic [ID_W-1:0]        result_id,
    output logic [PORT_TICK_W-1:0] result_tick
);

    stdq_cmd_t cmd;

    stdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    stdq_datapath #(
        .MAX_TIMERS (MAX_TIMERS),
        .TICK_BITS  (TICK_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .operation       (operation),
        .timer_id        (timer_id),
        .deadline_tick   (deadline_tick),
        .current_tick    (current_tick),
        .status          (status),
        .found           (found),
        .result_id       (result_id),
        .result_tick     (result_tick)
    );

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the sorted timer deadline queue: random and directed requests
// are compared against a behavioral copy of the timer ordering kept inside the bench.
// Depends on stdq_pkg and sorted_timer_deadline_queue.
module tb_top;
    import stdq_pkg::*;

    localparam int DEPTH         = MAX_TIMERS_DEF;
    localparam int RAND_PER_PHASE = 282;
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = 8;
    localparam int RUN_LIMIT     = 2_000_000;
    localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [ID_W-1:0]        id;
        logic [PORT_TICK_W-1:0] exp_tick;
        logic [PORT_TICK_W-1:0] now_tick;
    } timer_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    st;
        logic                   hit;
        logic [ID_W-1:0]        rid;
        logic [PORT_TICK_W-1:0] rtick;
    } timer_answer_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [OP_W-1:0]        operation = '0;
    logic [ID_W-1:0]        timer_id = '0;
    logic [PORT_TICK_W-1:0] deadline_tick = '0;
    logic [PORT_TICK_W-1:0] current_tick = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic                   found;
    logic [ID_W-1:0]        result_id;
    logic [PORT_TICK_W-1:0] result_tick;

    timer_req_t    req_q[$];
    timer_answer_t answer_q[$];
    int unsigned   pushed = 0;
    int unsigned   answered = 0;
    int unsigned   err_count = 0;
    int            send_gap_pct = 0;
    int            recv_stall_pct = 0;
    bit            hold_go = 1'b0;
    logic          rx_hold = 1'b0;

    logic [ID_W-1:0]        q_ids[DEPTH];
    logic [PORT_TICK_W-1:0] q_ticks[DEPTH];
    int                     q_len = 0;
    bit                     q_member[ID_SPACE];
    bit                     plan_member[ID_SPACE];

    sorted_timer_deadline_queue u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .timer_id       (timer_id),
        .deadline_tick  (deadline_tick),
        .current_tick   (current_tick),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .found          (found),
        .result_id      (result_id),
        .result_tick    (result_tick)
    );

    always #5 clk = ~clk;

    function automatic bit tick_earlier(logic [PORT_TICK_W-1:0] a, logic [PORT_TICK_W-1:0] b);
        logic [PORT_TICK_W-1:0] d;
        d = a - b;
        return d[PORT_TICK_W-1];
    endfunction

    function automatic timer_answer_t predict_timer_answer(timer_req_t r);
        timer_answer_t a;
        int pos;
        int i;
        a = '0;
        a.st = ST_OK;
        case (r.op)
            OP_INSERT:
            begin
                if (q_member[r.id])
                begin
                    a.st = ST_ALREADY;
                end
                else if (q_len >= DEPTH)
                begin
                    a.st = ST_FULL;
                end
                else
                begin
                    pos = q_len;
                    for (i = 0; i < q_len; i++)
                    begin
                        if (tick_earlier(r.exp_tick, q_ticks[i]))
                        begin
                            pos = i;
                            break;
                        end
                    end
                    for (i = q_len; i > pos; i--)
                    begin
                        q_ids[i] = q_ids[i-1];
                        q_ticks[i] = q_ticks[i-1];
                    end
                    q_ids[pos] = r.id;
                    q_ticks[pos] = r.exp_tick;
                    q_len++;
                    q_member[r.id] = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (!q_member[r.id])
                begin
                    a.st = ST_NOT_QUEUED;
                end
                else
                begin
                    for (pos = 0; pos < q_len; pos++)
                    begin
                        if (q_ids[pos] == r.id)
                        begin
                            break;
                        end
                    end
                    if (pos < q_len)
                    begin
                        for (i = pos; i + 1 < q_len; i++)
                        begin
                            q_ids[i] = q_ids[i+1];
                            q_ticks[i] = q_ticks[i+1];
                        end
                        q_len--;
                    end
                    q_member[r.id] = 1'b0;
                end
            end
            OP_PEEK:
            begin
                if (q_len == 0)
                begin
                    a.st = ST_EMPTY;
                end
                else if (tick_earlier(r.now_tick, q_ticks[0]))
                begin
                    a.st = ST_NOT_EXPIRED;
                end
                else
                begin
                    a.hit = 1'b1;
                    a.rid = q_ids[0];
                end
            end
            OP_NEXT:
            begin
                if (q_len == 0)
                begin
                    a.st = ST_EMPTY;
                end
                else
                begin
                    a.hit = 1'b1;
                    a.rtick = q_ticks[0];
                end
            end
            OP_CONTAINS:
            begin
                a.hit = q_member[r.id];
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    task automatic check_field(string name, logic [PORT_TICK_W-1:0] want,
                               logic [PORT_TICK_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            err_count++;
        end
    endtask

    task automatic queue_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                 logic [PORT_TICK_W-1:0] et, logic [PORT_TICK_W-1:0] nt);
        timer_req_t r;
        r.op = op;
        r.id = id;
        r.exp_tick = et;
        r.now_tick = nt;
        req_q.push_back(r);
        pushed++;
    endtask

    function automatic logic [ID_W-1:0] pick_id(bit armed);
        logic [ID_W-1:0] pool[$];
        for (int i = 0; i < ID_SPACE; i++)
        begin
            if (plan_member[i] == armed)
            begin
                pool.push_back(i[ID_W-1:0]);
            end
        end
        if (pool.size() == 0)
        begin
            return ID_W'($urandom_range(0, ID_SPACE - 1));
        end
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        timer_req_t nxt;
        timer_req_t seen;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            operation <= '0;
            timer_id <= '0;
            deadline_tick <= '0;
            current_tick <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                seen.op = operation;
                seen.id = timer_id;
                seen.exp_tick = deadline_tick;
                seen.now_tick = current_tick;
                answer_q.push_back(predict_timer_answer(seen));
            end
            if (!in_valid || in_ready)
            begin
                if (req_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    nxt = req_q.pop_front();
                    operation <= nxt.op;
                    timer_id <= nxt.id;
                    deadline_tick <= nxt.exp_tick;
                    current_tick <= nxt.now_tick;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        timer_answer_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (answer_q.size() == 0)
                begin
                    $error("result arrived with no request outstanding");
                    err_count++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    check_field("status", PORT_TICK_W'(want.st), PORT_TICK_W'(status));
                    check_field("found", PORT_TICK_W'(want.hit), PORT_TICK_W'(found));
                    check_field("result_id", PORT_TICK_W'(want.rid), PORT_TICK_W'(result_id));
                    check_field("result_tick", want.rtick, result_tick);
                    answered++;
                end
            end
            out_ready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int roll;
        int ins_pct;
        int rem_pct;
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] id;
        logic [PORT_TICK_W-1:0] et;
        logic [PORT_TICK_W-1:0] nt;
        logic [PORT_TICK_W-1:0] base;

        wait (rst_n === 1'b1);

        // Empty queue, absent timers and the unused operation codes.
        queue_request(OP_PEEK, 4'd0, $urandom, 32'h0000_0000);
        queue_request(OP_NEXT, 4'd15, $urandom, 32'hFFFF_FFFF);
        queue_request(OP_REMOVE, 4'd3, $urandom, $urandom);
        queue_request(OP_CONTAINS, 4'd0, $urandom, $urandom);
        for (int k = OP_RSVD_LO; k <= OP_RSVD_HI; k++)
        begin
            queue_request(k[OP_W-1:0], ID_W'($urandom), $urandom, $urandom);
        end

        // Tick extremes, wrap-around neighbors and a pair of equal deadlines.
        queue_request(OP_INSERT, 4'd0, 32'h0000_0000, $urandom);
        queue_request(OP_INSERT, 4'd15, 32'hFFFF_FFFF, $urandom);
        queue_request(OP_INSERT, 4'd7, 32'h7FFF_FFFF, $urandom);
        queue_request(OP_INSERT, 4'd8, 32'h8000_0000, $urandom);
        queue_request(OP_INSERT, 4'd1, 32'h0000_0064, $urandom);
        queue_request(OP_INSERT, 4'd2, 32'h0000_0064, $urandom);
        queue_request(OP_INSERT, 4'd3, 32'h0000_0032, $urandom);
        queue_request(OP_INSERT, 4'd4, 32'h0000_03E8, $urandom);
        queue_request(OP_INSERT, 4'd7, 32'h0000_0010, $urandom);
        queue_request(OP_PEEK, 4'd0, 32'h0000_0000, 32'h0000_0000);
        queue_request(OP_PEEK, 4'd0, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_request(OP_NEXT, 4'd0, $urandom, $urandom);
        queue_request(OP_CONTAINS, 4'd15, $urandom, $urandom);
        queue_request(OP_REMOVE, 4'd15, $urandom, $urandom);
        queue_request(OP_REMOVE, 4'd15, $urandom, $urandom);
        foreach (plan_member[i])
        begin
            plan_member[i] = 1'b0;
        end
        plan_member[0] = 1'b1;
        plan_member[1] = 1'b1;
        plan_member[2] = 1'b1;
        plan_member[3] = 1'b1;
        plan_member[4] = 1'b1;
        plan_member[7] = 1'b1;
        plan_member[8] = 1'b1;

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_gap_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_gap_pct = 68;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    recv_stall_pct = 68;
                end
                default:
                begin
                    send_gap_pct = 6;
                    recv_stall_pct = 6;
                end
            endcase
            base = $urandom;
            for (int k = 0; k < RAND_PER_PHASE; k++)
            begin
                // Alternate stretches that fill the queue with stretches that drain it.
                ins_pct = ((k / 48) % 2 == 0) ? 45 : 20;
                rem_pct = 60 - ins_pct;
                roll = $urandom_range(0, 99);
                if (roll < ins_pct)
                begin
                    op = OP_INSERT;
                    id = ($urandom_range(0, 3) != 0) ? pick_id(1'b0) : ID_W'($urandom);
                    plan_member[id] = 1'b1;
                end
                else if (roll < 60)
                begin
                    op = OP_REMOVE;
                    id = ($urandom_range(0, 3) != 0) ? pick_id(1'b1) : ID_W'($urandom);
                    plan_member[id] = 1'b0;
                end
                else
                begin
                    if (roll < 75)
                    begin
                        op = OP_PEEK;
                    end
                    else if (roll < 85)
                    begin
                        op = OP_NEXT;
                    end
                    else if (roll < 95)
                    begin
                        op = OP_CONTAINS;
                    end
                    else
                    begin
                        op = OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
                    end
                    id = ID_W'($urandom);
                end
                roll = $urandom_range(0, 15);
                if (roll == 0)
                begin
                    et = $urandom;
                end
                else if (roll < 5)
                begin
                    et = base + $urandom_range(0, 7);
                end
                else
                begin
                    et = base + $urandom_range(0, 400);
                end
                nt = ($urandom_range(0, 15) == 0) ? $urandom : base + $urandom_range(0, 450);
                if (op == OP_PEEK)
                begin
                    base = base + $urandom_range(0, 60);
                end
                queue_request(op, id, et, nt);
            end
            if (ph == 0)
            begin
                hold_go = 1'b1;
            end
            while (answered != pushed)
            begin
                @(posedge clk);
            end
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/stdq_pkg.sv
rtl/core/stdq_ctrl.sv
rtl/core/stdq_datapath.sv
rtl/core/sorted_timer_deadline_queue.sv
dv/tb_top.sv
